// ----- src/lift_pkg.sv -----
// Package for the LOOK elevator scheduler: request and result structs,
// heap sizing constants and action codes. No dependencies.
package lift_pkg;

  localparam int HEAP_DEPTH = 1024;
  localparam int FLOOR_BITS = 16;
  localparam int IDX_W      = $clog2(HEAP_DEPTH);
  localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_CANCEL = 2'd1;
  localparam logic [1:0] ACT_SERVE  = 2'd2;
  localparam logic [1:0] ACT_REPORT = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] floor;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [15:0] position;
  } rsp_t;

endpackage

// ----- src/look_elevator_scheduler.sv -----
// LOOK elevator scheduler: four binary heaps in one flattened on-chip memory,
// a shared compare unit and a small sequencer. Depends on lift_pkg.
// Report and dropped add/cancel answer in the accept cycle; an add or cancel
// then stays busy while it walks up the heap. Serve checks each side, then
// pops; each pop reads the last entry, writes it to the root and sifts down.
// Throughput: one request at a time, busy meanwhile. Reset: synchronous active
// low; clears counts, floor and direction, heap memory is not cleared. The
// receiver cannot stall results.
module look_elevator_scheduler (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  lift_pkg::req_t    in_req,
  output logic              out_valid,
  output lift_pkg::rsp_t    out_rsp
);

  localparam int IW = lift_pkg::IDX_W;
  localparam int CW = lift_pkg::CNT_W;
  localparam int FW = lift_pkg::FLOOR_BITS;

  // heap ids: 0 up pending, 1 up cancels, 2 down pending, 3 down cancels
  localparam logic [1:0] H_UP_P = 2'd0;
  localparam logic [1:0] H_UP_C = 2'd1;
  localparam logic [1:0] H_DN_P = 2'd2;
  localparam logic [1:0] H_DN_C = 2'd3;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PUSH_R = 4'd1;  // read parent
  localparam logic [3:0] S_PUSH_C = 4'd2;  // compare, swap
  localparam logic [3:0] S_CHK_R  = 4'd3;  // read pending top
  localparam logic [3:0] S_CHK_C  = 4'd4;  // read cancel top, compare tops
  localparam logic [3:0] S_POP_L  = 4'd5;  // read last
  localparam logic [3:0] S_POP_W  = 4'd6;  // write last to root
  localparam logic [3:0] S_SIFT_R = 4'd7;  // read left child
  localparam logic [3:0] S_SIFT_K = 4'd8;  // read right
  localparam logic [3:0] S_SIFT_C = 4'd9;  // pick child, compare, swap
  localparam logic [3:0] S_SERVE  = 4'd10;
  localparam logic [3:0] S_SRV_R  = 4'd11;

  // one memory per heap, flattened into a single array with heap id on top
  logic [FW-1:0] mem_r [4*lift_pkg::HEAP_DEPTH];

  logic [3:0]    state_r;
  logic [CW-1:0] cnt_r [4];
  logic [FW-1:0] car_r;
  logic          down_r;
  logic [1:0]    heap_r;      // heap being worked
  logic          side_r;      // cleanup side: 0 up, 1 down
  logic          pair_r;      // popping cancel heap after pending
  logic          serving_r;   // pop is the final serve
  logic [IW-1:0] cur_r;
  logic [IW-1:0] kid_r;
  logic [FW-1:0] a_r, b_r;
  logic          rd_en;
  logic [IW+1:0] rd_addr;
  logic [FW-1:0] rd_data_r;
  logic          wr_en, wr2_en;
  logic [IW+1:0] wr_addr, wr2_addr;
  logic [FW-1:0] wr_data, wr2_data;
  logic          is_max;
  logic          cmp_lt;      // shared compare: x before y in heap order
  logic [FW-1:0] cmp_x, cmp_y;
  logic          rd_vld_r;
  logic          pop_end;     // current pop is finished

  assign is_max = heap_r[1];
  always_comb begin
    cmp_lt = is_max ? (cmp_x > cmp_y) : (cmp_x < cmp_y);
  end

  // memory: one read port (registered), writes from sequencer
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= wr_data;
    if (wr2_en) mem_r[wr2_addr] <= wr2_data;
    if (rd_en) rd_data_r <= mem_r[rd_addr];
  end

  logic [FW-1:0] fl;
  logic          up_side;
  logic [1:0]    tgt;
  assign fl      = in_req.floor[FW-1:0];
  assign up_side = fl > car_r;
  assign tgt     = {~up_side, (in_req.action == lift_pkg::ACT_CANCEL)};
  assign busy    = (state_r != S_IDLE);

  logic [3:0]    state_nxt;
  logic [CW-1:0] cnt_nxt [4];
  logic [FW-1:0] car_nxt;
  logic          down_nxt, side_nxt, pair_nxt, serving_nxt, rd_vld_nxt;
  logic [1:0]    heap_nxt;
  logic [IW-1:0] cur_nxt, kid_nxt;
  logic [FW-1:0] a_nxt, b_nxt;
  logic [CW-1:0] n;
  logic [CW:0]   k2;

  assign n = cnt_r[heap_r];

  // sequencer
  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; car_nxt = car_r; down_nxt = down_r;
    heap_nxt = heap_r; side_nxt = side_r; pair_nxt = pair_r;
    serving_nxt = serving_r; cur_nxt = cur_r; kid_nxt = kid_r;
    a_nxt = a_r; b_nxt = b_r; rd_vld_nxt = 1'b0;
    rd_en = 1'b0; rd_addr = '0;
    wr_en = 1'b0; wr_addr = '0; wr_data = '0;
    wr2_en = 1'b0; wr2_addr = '0; wr2_data = '0;
    cmp_x = a_r; cmp_y = b_r; k2 = '0; pop_end = 1'b0;
    out_valid = 1'b0; out_rsp.status = 1'b0;
    out_rsp.position = 16'(car_r);
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_req.action)
            lift_pkg::ACT_ADD, lift_pkg::ACT_CANCEL: begin
              if (cnt_r[tgt] >= CW'(lift_pkg::HEAP_DEPTH)) begin
                out_valid = 1'b1; out_rsp.status = 1'b1;
              end else begin
                wr_en = 1'b1; wr_addr = {tgt, cnt_r[tgt][IW-1:0]}; wr_data = fl;
                cnt_nxt[tgt] = cnt_r[tgt] + 1'b1;
                heap_nxt = tgt; cur_nxt = cnt_r[tgt][IW-1:0]; a_nxt = fl;
                state_nxt = S_PUSH_R;
              end
            end
            lift_pkg::ACT_SERVE: begin
              side_nxt = 1'b0; state_nxt = S_CHK_R;
            end
            default: begin
              out_valid = 1'b1;
            end
          endcase
        end
      end
      // push: cur holds value a_r; read parent
      S_PUSH_R: begin
        if (cur_r == '0) state_nxt = S_IDLE;
        else begin
          kid_nxt = (cur_r - 1'b1) >> 1;
          rd_en = 1'b1; rd_addr = {heap_r, (cur_r - 1'b1) >> 1};
          state_nxt = S_PUSH_C;
        end
      end
      S_PUSH_C: begin
        cmp_x = a_r; cmp_y = rd_data_r;
        if (cmp_lt) begin
          wr_en = 1'b1; wr_addr = {heap_r, cur_r}; wr_data = rd_data_r;
          wr2_en = 1'b1; wr2_addr = {heap_r, kid_r}; wr2_data = a_r;
          cur_nxt = kid_r; state_nxt = S_PUSH_R;
        end else state_nxt = S_IDLE;
      end
      // cleanup: read pending top then cancel top
      S_CHK_R: begin
        if (cnt_r[{side_r, 1'b0}] == '0 || cnt_r[{side_r, 1'b1}] == '0) begin
          if (side_r) state_nxt = S_SERVE;
          else side_nxt = 1'b1;
        end else begin
          rd_en = 1'b1; rd_addr = {side_r, 1'b0, {IW{1'b0}}};
          rd_vld_nxt = 1'b1;
          state_nxt = S_CHK_C;
        end
      end
      S_CHK_C: begin
        if (rd_vld_r) begin
          a_nxt = rd_data_r;
          rd_en = 1'b1; rd_addr = {side_r, 1'b1, {IW{1'b0}}};
        end else begin
          if (a_r == rd_data_r) begin
            heap_nxt = {side_r, 1'b0}; pair_nxt = 1'b1; serving_nxt = 1'b0;
            state_nxt = S_POP_L;
          end else if (side_r) state_nxt = S_SERVE;
          else begin side_nxt = 1'b1; state_nxt = S_CHK_R; end
        end
      end
      S_SERVE: begin
        pair_nxt = 1'b0; serving_nxt = 1'b1;
        if (!down_r) begin
          if (cnt_r[H_UP_P] != '0) begin heap_nxt = H_UP_P; state_nxt = S_SRV_R; end
          else if (cnt_r[H_DN_P] != '0) begin
            down_nxt = 1'b1; heap_nxt = H_DN_P; state_nxt = S_SRV_R;
          end else state_nxt = S_IDLE;
        end else begin
          if (cnt_r[H_DN_P] != '0) begin heap_nxt = H_DN_P; state_nxt = S_SRV_R; end
          else if (cnt_r[H_UP_P] != '0) begin
            down_nxt = 1'b0; heap_nxt = H_UP_P; state_nxt = S_SRV_R;
          end else state_nxt = S_IDLE;
        end
      end
      S_SRV_R: begin
        rd_en = 1'b1; rd_addr = {heap_r, {IW{1'b0}}};
        rd_vld_nxt = 1'b1; state_nxt = S_POP_L;
      end
      // pop: read last entry, write to root, shrink count
      S_POP_L: begin
        if (serving_r && rd_vld_r) car_nxt = rd_data_r;
        rd_en = 1'b1; rd_addr = {heap_r, IW'(n - 1'b1)};
        cnt_nxt[heap_r] = n - 1'b1;
        state_nxt = S_POP_W;
      end
      S_POP_W: begin
        wr_en = 1'b1; wr_addr = {heap_r, {IW{1'b0}}}; wr_data = rd_data_r;
        a_nxt = rd_data_r; cur_nxt = '0; state_nxt = S_SIFT_R;
      end
      S_SIFT_R: begin
        k2 = {1'b0, cur_r, 1'b1};
        if (k2 >= (CW+1)'(n)) pop_end = 1'b1;
        else begin
          rd_en = 1'b1; rd_addr = {heap_r, k2[IW-1:0]};
          kid_nxt = k2[IW-1:0]; state_nxt = S_SIFT_K;
        end
      end
      S_SIFT_K: begin
        b_nxt = rd_data_r;
        k2 = (CW+1)'(kid_r) + 1'b1;
        rd_vld_nxt = (k2 < (CW+1)'(n));
        rd_en = 1'b1; rd_addr = {heap_r, k2[IW-1:0]};
        state_nxt = S_SIFT_C;
      end
      S_SIFT_C: begin
        if (rd_vld_r) begin
          cmp_x = rd_data_r; cmp_y = b_r;
          if (cmp_lt) kid_nxt = kid_r + 1'b1;
        end
        state_nxt = S_SIFT_R;
        // compare chosen child against moving value
        if (rd_vld_r && cmp_lt) begin
          if (is_max ? (rd_data_r > a_r) : (rd_data_r < a_r)) begin
            wr_en = 1'b1; wr_addr = {heap_r, cur_r}; wr_data = rd_data_r;
            wr2_en = 1'b1; wr2_addr = {heap_r, kid_r + 1'b1}; wr2_data = a_r;
            cur_nxt = kid_r + 1'b1;
          end else pop_end = 1'b1;
        end else begin
          if (is_max ? (b_r > a_r) : (b_r < a_r)) begin
            wr_en = 1'b1; wr_addr = {heap_r, cur_r}; wr_data = b_r;
            wr2_en = 1'b1; wr2_addr = {heap_r, kid_r}; wr2_data = a_r;
            cur_nxt = kid_r;
          end else pop_end = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // leave a pop: continue paired pop, go back to cleanup, or finish
    if (pop_end) begin
      if (pair_r && !heap_r[0]) begin
        heap_nxt = heap_r | 2'd1; state_nxt = S_POP_L;
      end else if (pair_r) state_nxt = S_CHK_R;
      else state_nxt = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < 4; i++) cnt_r[i] <= '0;
      car_r <= '0; down_r <= 1'b0; rd_vld_r <= 1'b0;
      pair_r <= 1'b0; serving_r <= 1'b0; side_r <= 1'b0; heap_r <= '0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; car_r <= car_nxt;
      down_r <= down_nxt; rd_vld_r <= rd_vld_nxt; pair_r <= pair_nxt;
      serving_r <= serving_nxt; side_r <= side_nxt; heap_r <= heap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt; kid_r <= kid_nxt;
    a_r <= a_nxt; b_r <= b_nxt;
  end

  // results come only from an accepted request in idle
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == S_IDLE && start))
    else $error("result outside accept");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[heap_r] <= CW'(lift_pkg::HEAP_DEPTH))
    else $error("heap count overflow");
  a_report: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req.action == lift_pkg::ACT_REPORT) |-> out_valid)
    else $error("report lost");

endmodule

// ----- test/tb_look_elevator_scheduler.sv -----
// Testbench for look_elevator_scheduler: directed and random requests checked
// against a behavioral LOOK scheduler kept in this file. Depends on lift_pkg.
`timescale 1ns / 1ps

module tb_look_elevator_scheduler;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  lift_pkg::req_t in_req;
  logic out_valid;
  lift_pkg::rsp_t out_rsp;

  look_elevator_scheduler dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_valid(out_valid), .out_rsp(out_rsp)
  );

  // Scheduler state mirrored in the testbench
  logic [15:0] up_wait[$];
  logic [15:0] up_drop[$];
  logic [15:0] dn_wait[$];
  logic [15:0] dn_drop[$];
  logic [15:0] car_at;
  logic        going_down;
  lift_pkg::rsp_t pending_rsp[$];

  int  errors = 0;
  int  requests_sent = 0;
  int  reports_seen = 0;
  int  drops_seen = 0;
  int  serves_sent = 0;
  bit  allow_idle = 1;
  longint cycle_count = 0;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Heaps held as sorted queues: up ascending, down descending
  function automatic void sorted_insert(ref logic [15:0] q[$], input logic [15:0] v,
                                        input bit descending);
    int i;
    i = 0;
    while (i < q.size() && (descending ? q[i] >= v : q[i] <= v)) i++;
    q.insert(i, v);
  endfunction

  function automatic void drop_pairs(ref logic [15:0] w[$], ref logic [15:0] c[$]);
    while (w.size() > 0 && c.size() > 0 && w[0] == c[0]) begin
      void'(w.pop_front());
      void'(c.pop_front());
    end
  endfunction

  // Work out the response (if any) of one request and advance the mirror
  function automatic void predict_schedule(lift_pkg::req_t r);
    bit   up_side;
    lift_pkg::rsp_t rsp;
    up_side = r.floor > car_at;
    rsp.position = car_at;
    rsp.status = 1'b0;
    case (r.action)
      lift_pkg::ACT_ADD, lift_pkg::ACT_CANCEL: begin
        if (r.action == lift_pkg::ACT_ADD) begin
          if ((up_side ? up_wait.size() : dn_wait.size()) >= lift_pkg::HEAP_DEPTH) begin
            rsp.status = 1'b1;
            pending_rsp.push_back(rsp);
          end else if (up_side) sorted_insert(up_wait, r.floor, 1'b0);
          else sorted_insert(dn_wait, r.floor, 1'b1);
        end else begin
          if ((up_side ? up_drop.size() : dn_drop.size()) >= lift_pkg::HEAP_DEPTH) begin
            rsp.status = 1'b1;
            pending_rsp.push_back(rsp);
          end else if (up_side) sorted_insert(up_drop, r.floor, 1'b0);
          else sorted_insert(dn_drop, r.floor, 1'b1);
        end
      end
      lift_pkg::ACT_SERVE: begin
        drop_pairs(up_wait, up_drop);
        drop_pairs(dn_wait, dn_drop);
        if (!going_down) begin
          if (up_wait.size() > 0) car_at = up_wait.pop_front();
          else if (dn_wait.size() > 0) begin
            going_down = 1'b1;
            car_at = dn_wait.pop_front();
          end
        end else begin
          if (dn_wait.size() > 0) car_at = dn_wait.pop_front();
          else if (up_wait.size() > 0) begin
            going_down = 1'b0;
            car_at = up_wait.pop_front();
          end
        end
      end
      default: begin
        rsp.status = 1'b0;
        pending_rsp.push_back(rsp);
      end
    endcase
  endfunction

  // Send one request, with optional random idle burst first; start stays
  // high after the accepting edge until the next call or the end of the run
  task automatic send_request(logic [1:0] act, logic [15:0] fl);
    lift_pkg::req_t r;
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      in_req <= 18'($urandom);
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    r.action = act;
    r.floor = fl;
    start <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    requests_sent++;
    if (act == lift_pkg::ACT_SERVE) serves_sent++;
  endtask

  // Predict each accepted request, then compare every result with the oldest
  // expected one
  always @(posedge clk) begin
    lift_pkg::rsp_t exp_rsp;
    if (rst_n && start && !busy) predict_schedule(in_req);
    if (rst_n && out_valid) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected result: status %0d position %0d",
               out_rsp.status, out_rsp.position);
        errors++;
      end else begin
        exp_rsp = pending_rsp.pop_front();
        if (out_rsp.status !== exp_rsp.status) begin
          $error("status: expected %0d, got %0d", exp_rsp.status, out_rsp.status);
          errors++;
        end
        if (out_rsp.position !== exp_rsp.position) begin
          $error("position: expected %0d, got %0d", exp_rsp.position, out_rsp.position);
          errors++;
        end
        if (exp_rsp.status) drops_seen++;
        else reports_seen++;
      end
    end
  end

  // Guard against a hang
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 4000000) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** look_elevator_scheduler: FAILED **");
      $finish;
    end
  end

  task automatic test_edges();
    send_request(lift_pkg::ACT_REPORT, 16'd0);
    send_request(lift_pkg::ACT_SERVE, 16'd0);
    send_request(lift_pkg::ACT_ADD, 16'd0);
    send_request(lift_pkg::ACT_ADD, 16'hFFFF);
    send_request(lift_pkg::ACT_ADD, 16'd5);
    send_request(lift_pkg::ACT_ADD, 16'd5);
    send_request(lift_pkg::ACT_CANCEL, 16'd5);
    send_request(lift_pkg::ACT_CANCEL, 16'd77);
    send_request(lift_pkg::ACT_ADD, 16'hAAAA);
    send_request(lift_pkg::ACT_ADD, 16'h5555);
    repeat (6) begin
      send_request(lift_pkg::ACT_SERVE, 16'd0);
      send_request(lift_pkg::ACT_REPORT, 16'hFFFF);
    end
    send_request(lift_pkg::ACT_ADD, 16'd3);
    send_request(lift_pkg::ACT_CANCEL, 16'd3);
    send_request(lift_pkg::ACT_SERVE, 16'd0);
    send_request(lift_pkg::ACT_REPORT, 16'd0);
  endtask

  // Mostly well-formed traffic: adds mostly near the car, cancels mostly of live requests, serves, reports
  task automatic test_random_traffic(int n);
    logic [15:0] fl;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) fl = 16'($urandom);
      else fl = car_at + 16'($urandom_range(0, 64)) - 16'd32;
      if (pick < 40) send_request(lift_pkg::ACT_ADD, fl);
      else if (pick < 50) begin
        if (up_wait.size() > 0 && pick < 45)
          send_request(lift_pkg::ACT_CANCEL, up_wait[$urandom_range(0, up_wait.size() - 1)]);
        else if (dn_wait.size() > 0)
          send_request(lift_pkg::ACT_CANCEL, dn_wait[$urandom_range(0, dn_wait.size() - 1)]);
        else send_request(lift_pkg::ACT_CANCEL, fl);
      end else if (pick < 75) send_request(lift_pkg::ACT_SERVE, 16'($urandom));
      else send_request(lift_pkg::ACT_REPORT, 16'($urandom));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    car_at = '0;
    going_down = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edges();
    test_random_traffic(620);
    allow_idle = 0;
    test_random_traffic(100);
    start <= 1'b0;
    while (pending_rsp.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d requests (%0d serves), %0d reports and %0d drops checked",
             requests_sent, serves_sent, reports_seen, drops_seen);
    if (errors == 0) $display("** look_elevator_scheduler: PASSED **");
    else $display("** look_elevator_scheduler: FAILED **");
    $finish;
  end

endmodule
